@@ src/bcd_pkg.sv @@
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the button click detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned DebW  = 3;
  localparam int unsigned EvW   = 3;
  localparam int unsigned RepW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};
  localparam logic [RepW-1:0]  RepMax  = {RepW{1'b1}};

  typedef enum logic [EvW-1:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_REPEAT = 3'd3,
    EV_SINGLE = 3'd4,
    EV_DOUBLE = 3'd5,
    EV_LSTART = 3'd6,
    EV_LHOLD  = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_SHORT    = 2'd1,
    REG_LONG     = 2'd2,
    REG_ACTIVE   = 2'd3
  } cfg_reg_e;

  localparam logic [DebW-1:0]  DebounceReset = 3'd3;
  localparam logic [TickW-1:0] ShortReset    = 16'd60;
  localparam logic [TickW-1:0] LongReset     = 16'd200;
  localparam logic             ActiveReset   = 1'b0;

  typedef struct packed {
    logic [DebW-1:0]  deb_limit;
    logic [TickW-1:0] short_limit;
    logic [TickW-1:0] long_limit;
    logic             press_level;
  } cfg_t;

  typedef struct packed {
    event_e event_code;
    logic   down_fired;
    logic   up_fired;
    logic   repeat_fired;
    logic   single_fired;
    logic   double_fired;
    logic   long_start_fired;
    logic   long_hold_fired;
    logic   toggle_request;
    logic   stable_level;
  } result_t;

endpackage

@@ src/bcd_input_stage.sv @@
// ----------------------------------------------------------------------------
// bcd_input_stage
// Input register holding one sampled pin level until the step logic takes it.
// ----------------------------------------------------------------------------
module bcd_input_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic pin_level_i,
  input  logic advance_i,
  output logic valid_o,
  output logic level_o
);

  logic valid_q, valid_d;
  logic level_q, level_d;
  logic take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    level_d = level_q;
    if (take) begin
      valid_d = 1'b1;
      level_d = pin_level_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign valid_o = valid_q;
  assign level_o = level_q;

endmodule

@@ src/bcd_fsm.sv @@
// ----------------------------------------------------------------------------
// bcd_fsm
// Debounce counter and click phase machine, one tick per enabled cycle.
// ----------------------------------------------------------------------------
module bcd_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             level_i,
  input  bcd_pkg::cfg_t    cfg_i,
  output bcd_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HELD     = 3'd1,
    PH_RELEASED = 3'd2,
    PH_AGAIN    = 3'd3,
    PH_LONG     = 3'd5
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [bcd_pkg::TickW-1:0]     tick_q, tick_d, tick_inc;
  logic [bcd_pkg::RepW-1:0]      rep_q, rep_d, rep_inc;
  logic [bcd_pkg::DebW-1:0]      deb_cnt_q, deb_cnt_d, deb_cnt_inc;
  logic                          deb_lvl_q, deb_lvl_d;
  bcd_pkg::event_e               last_q, last_d;
  logic                          pressed;
  logic f_down, f_up, f_rep, f_single, f_double, f_lstart, f_lhold;

  always_comb begin
    tick_inc = tick_q;
    if (phase_q != PH_IDLE && tick_q != bcd_pkg::TickMax) begin
      tick_inc = tick_q + 1'b1;
    end
    rep_inc     = (rep_q != bcd_pkg::RepMax) ? rep_q + 1'b1 : rep_q;
    deb_cnt_inc = deb_cnt_q + 1'b1;

    deb_lvl_d = deb_lvl_q;
    deb_cnt_d = '0;
    if (level_i != deb_lvl_q) begin
      if (deb_cnt_inc >= cfg_i.deb_limit) begin
        deb_lvl_d = level_i;
      end else begin
        deb_cnt_d = deb_cnt_inc;
      end
    end
    pressed = (deb_lvl_d == cfg_i.press_level);

    phase_d  = phase_q;
    tick_d   = tick_inc;
    rep_d    = rep_q;
    last_d   = last_q;
    f_down   = 1'b0;
    f_up     = 1'b0;
    f_rep    = 1'b0;
    f_single = 1'b0;
    f_double = 1'b0;
    f_lstart = 1'b0;
    f_lhold  = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (pressed) begin
          last_d  = bcd_pkg::EV_DOWN;
          f_down  = 1'b1;
          tick_d  = '0;
          rep_d   = {{(bcd_pkg::RepW-1){1'b0}}, 1'b1};
          phase_d = PH_HELD;
        end else begin
          last_d = bcd_pkg::EV_NONE;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          last_d  = bcd_pkg::EV_UP;
          f_up    = 1'b1;
          tick_d  = '0;
          phase_d = PH_RELEASED;
        end else if (tick_inc > cfg_i.long_limit) begin
          last_d   = bcd_pkg::EV_LSTART;
          f_lstart = 1'b1;
          phase_d  = PH_LONG;
        end
      end
      PH_RELEASED: begin
        if (pressed) begin
          last_d   = bcd_pkg::EV_DOWN;
          f_down   = 1'b1;
          rep_d    = rep_inc;
          f_double = (rep_inc == bcd_pkg::RepW'(2));
          f_rep    = 1'b1;
          tick_d   = '0;
          phase_d  = PH_AGAIN;
        end else if (tick_inc > cfg_i.short_limit) begin
          if (rep_q == bcd_pkg::RepW'(1)) begin
            last_d   = bcd_pkg::EV_SINGLE;
            f_single = 1'b1;
          end else if (rep_q == bcd_pkg::RepW'(2)) begin
            last_d = bcd_pkg::EV_DOUBLE;
          end
          phase_d = PH_IDLE;
        end
      end
      PH_AGAIN: begin
        if (!pressed) begin
          last_d = bcd_pkg::EV_UP;
          f_up   = 1'b1;
          if (tick_inc < cfg_i.short_limit) begin
            tick_d  = '0;
            phase_d = PH_RELEASED;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_LONG: begin
        if (pressed) begin
          last_d  = bcd_pkg::EV_LHOLD;
          f_lhold = 1'b1;
        end else begin
          last_d  = bcd_pkg::EV_UP;
          f_up    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      rep_q     <= '0;
      deb_cnt_q <= '0;
      deb_lvl_q <= 1'b0;
      last_q    <= bcd_pkg::EV_NONE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      rep_q     <= rep_d;
      deb_cnt_q <= deb_cnt_d;
      deb_lvl_q <= deb_lvl_d;
      last_q    <= last_d;
    end
  end

  assign result_o.event_code       = last_d;
  assign result_o.down_fired       = f_down;
  assign result_o.up_fired         = f_up;
  assign result_o.repeat_fired     = f_rep;
  assign result_o.single_fired     = f_single;
  assign result_o.double_fired     = f_double;
  assign result_o.long_start_fired = f_lstart;
  assign result_o.long_hold_fired  = f_lhold;
  assign result_o.toggle_request   = f_single || f_double;
  assign result_o.stable_level     = deb_lvl_d;

endmodule

@@ src/bcd_output_stage.sv @@
// ----------------------------------------------------------------------------
// bcd_output_stage
// Result register with valid and ready toward the consumer.
// ----------------------------------------------------------------------------
module bcd_output_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bcd_pkg::result_t result_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bcd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  bcd_pkg::result_t result_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ src/button_click_detector_core.sv @@
// ----------------------------------------------------------------------------
// button_click_detector_core
// Debounced button click detector: one pin level tick in, one event item out.
// ----------------------------------------------------------------------------
// path: a tick item waits in the input register until the result register has
// space, then its result is registered there; throughput: one item per cycle
// while out_ready_i holds, set by the state update between the two registers
// reset: clears phase, counters, debounced level and latched event, and
// loads the configuration registers with their default values
module button_click_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          pin_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bcd_pkg::EvW-1:0]       event_code_o,
  output logic                          down_fired_o,
  output logic                          up_fired_o,
  output logic                          repeat_fired_o,
  output logic                          single_fired_o,
  output logic                          double_fired_o,
  output logic                          long_start_fired_o,
  output logic                          long_hold_fired_o,
  output logic                          toggle_request_o,
  output logic                          stable_level_o
);

  bcd_pkg::cfg_t    cfg_q;
  bcd_pkg::result_t step_res;
  bcd_pkg::result_t out_res;
  logic             stage_valid;
  logic             stage_level;
  logic             out_space;
  logic             advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deb_limit   <= bcd_pkg::DebounceReset;
      cfg_q.short_limit <= bcd_pkg::ShortReset;
      cfg_q.long_limit  <= bcd_pkg::LongReset;
      cfg_q.press_level <= bcd_pkg::ActiveReset;
    end else if (cfg_valid_i) begin
      unique case (bcd_pkg::cfg_reg_e'(cfg_index_i))
        bcd_pkg::REG_DEBOUNCE: cfg_q.deb_limit   <= cfg_data_i[bcd_pkg::DebW-1:0];
        bcd_pkg::REG_SHORT:    cfg_q.short_limit <= cfg_data_i[bcd_pkg::TickW-1:0];
        bcd_pkg::REG_LONG:     cfg_q.long_limit  <= cfg_data_i[bcd_pkg::TickW-1:0];
        bcd_pkg::REG_ACTIVE:   cfg_q.press_level <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign advance = stage_valid && out_space;

  bcd_input_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pin_level_i (pin_level_i),
    .advance_i   (advance),
    .valid_o     (stage_valid),
    .level_o     (stage_level)
  );

  bcd_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .level_i  (stage_level),
    .cfg_i    (cfg_q),
    .result_o (step_res)
  );

  bcd_output_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign event_code_o       = out_res.event_code;
  assign down_fired_o       = out_res.down_fired;
  assign up_fired_o         = out_res.up_fired;
  assign repeat_fired_o     = out_res.repeat_fired;
  assign single_fired_o     = out_res.single_fired;
  assign double_fired_o     = out_res.double_fired;
  assign long_start_fired_o = out_res.long_start_fired;
  assign long_hold_fired_o  = out_res.long_hold_fired;
  assign toggle_request_o   = out_res.toggle_request;
  assign stable_level_o     = out_res.stable_level;

endmodule

@@ tb/tb_button_click_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_detector_core
// Drives pin level ticks through the click detector under several register
// settings, predicts every event item in a scoreboard and compares each
// returned item field by field, with random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_button_click_detector_core;
  import bcd_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxSeg        = 300;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HELD     = 3'd1,
    PH_RELEASED = 3'd2,
    PH_AGAIN    = 3'd3,
    PH_LONG     = 3'd5
  } click_phase_e;

  class click_scoreboard;
    logic [DebW-1:0]  deb_ticks;
    logic [TickW-1:0] short_lim;
    logic [TickW-1:0] long_lim;
    logic             active_lvl;
    click_phase_e     mode;
    logic [TickW-1:0] ticks;
    logic [RepW-1:0]  presses;
    logic [DebW-1:0]  deb_cnt;
    logic             stable;
    event_e           latched;
    result_t          expected_events[$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      deb_ticks  = DebounceReset;
      short_lim  = ShortReset;
      long_lim   = LongReset;
      active_lvl = ActiveReset;
      mode       = PH_IDLE;
      ticks      = '0;
      presses    = '0;
      deb_cnt    = '0;
      stable     = 1'b0;
      latched    = EV_NONE;
      errors     = 0;
      checked    = 0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function void note_cfg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        REG_DEBOUNCE: deb_ticks  = data[DebW-1:0];
        REG_SHORT:    short_lim  = data[TickW-1:0];
        REG_LONG:     long_lim   = data[TickW-1:0];
        REG_ACTIVE:   active_lvl = data[0];
        default: ;
      endcase
    endfunction

    function void note_tick(input logic lvl);
      result_t r;
      logic    pressed;
      r = '0;
      if (mode != PH_IDLE && ticks != TickMax) ticks = ticks + 1'b1;
      if (lvl != stable) begin
        deb_cnt = deb_cnt + 1'b1;
        if (deb_cnt >= deb_ticks) begin
          stable  = lvl;
          deb_cnt = '0;
        end
      end else begin
        deb_cnt = '0;
      end
      pressed = (stable == active_lvl);
      case (mode)
        PH_IDLE: begin
          if (pressed) begin
            latched      = EV_DOWN;
            r.down_fired = 1'b1;
            ticks        = '0;
            presses      = 3'd1;
            mode         = PH_HELD;
          end else begin
            latched = EV_NONE;
          end
        end
        PH_HELD: begin
          if (!pressed) begin
            latched    = EV_UP;
            r.up_fired = 1'b1;
            ticks      = '0;
            mode       = PH_RELEASED;
          end else if (ticks > long_lim) begin
            latched            = EV_LSTART;
            r.long_start_fired = 1'b1;
            mode               = PH_LONG;
          end
        end
        PH_RELEASED: begin
          if (pressed) begin
            latched      = EV_DOWN;
            r.down_fired = 1'b1;
            if (presses != RepMax) presses = presses + 1'b1;
            if (presses == 3'd2) r.double_fired = 1'b1;
            r.repeat_fired = 1'b1;
            ticks          = '0;
            mode           = PH_AGAIN;
          end else if (ticks > short_lim) begin
            // a double click only latches its code here, the flag fired at the press
            if (presses == 3'd1) begin
              latched        = EV_SINGLE;
              r.single_fired = 1'b1;
            end else if (presses == 3'd2) begin
              latched = EV_DOUBLE;
            end
            mode = PH_IDLE;
          end
        end
        PH_AGAIN: begin
          if (!pressed) begin
            latched    = EV_UP;
            r.up_fired = 1'b1;
            if (ticks < short_lim) begin
              ticks = '0;
              mode  = PH_RELEASED;
            end else begin
              mode = PH_IDLE;
            end
          end
        end
        PH_LONG: begin
          if (pressed) begin
            latched           = EV_LHOLD;
            r.long_hold_fired = 1'b1;
          end else begin
            latched    = EV_UP;
            r.up_fired = 1'b1;
            mode       = PH_IDLE;
          end
        end
        default: ;
      endcase
      r.event_code     = latched;
      r.toggle_request = r.single_fired | r.double_fired;
      r.stable_level   = stable;
      expected_events.push_back(r);
    endfunction

    task compare(input string name, input logic [EvW-1:0] got, input logic [EvW-1:0] want);
      if (got !== want)
        report($sformatf("item %0d %s got %0d want %0d", checked, name, got, want));
    endtask

    task check_result(input result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        report("event item with no tick item pending");
        return;
      end
      want = expected_events.pop_front();
      compare("event_code", got.event_code, want.event_code);
      compare("down_fired", EvW'(got.down_fired), EvW'(want.down_fired));
      compare("up_fired", EvW'(got.up_fired), EvW'(want.up_fired));
      compare("repeat_fired", EvW'(got.repeat_fired), EvW'(want.repeat_fired));
      compare("single_fired", EvW'(got.single_fired), EvW'(want.single_fired));
      compare("double_fired", EvW'(got.double_fired), EvW'(want.double_fired));
      compare("long_start_fired", EvW'(got.long_start_fired),
              EvW'(want.long_start_fired));
      compare("long_hold_fired", EvW'(got.long_hold_fired), EvW'(want.long_hold_fired));
      compare("toggle_request", EvW'(got.toggle_request), EvW'(want.toggle_request));
      compare("stable_level", EvW'(got.stable_level), EvW'(want.stable_level));
      checked++;
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                pin_level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [EvW-1:0]      event_code_o;
  logic                down_fired_o;
  logic                up_fired_o;
  logic                repeat_fired_o;
  logic                single_fired_o;
  logic                double_fired_o;
  logic                long_start_fired_o;
  logic                long_hold_fired_o;
  logic                toggle_request_o;
  logic                stable_level_o;

  click_scoreboard sb = new();
  result_t         seen_result;
  int unsigned     cycle_cnt = 0;
  int              burst_left = 0;
  bit              quiet = 1'b0;
  bit              hold_off_req = 1'b0;
  int              cur_deb;
  int              cur_short;
  int              cur_long;
  logic            cur_act;

  button_click_detector_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pin_level_i        (pin_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_code_o       (event_code_o),
    .down_fired_o       (down_fired_o),
    .up_fired_o         (up_fired_o),
    .repeat_fired_o     (repeat_fired_o),
    .single_fired_o     (single_fired_o),
    .double_fired_o     (double_fired_o),
    .long_start_fired_o (long_start_fired_o),
    .long_hold_fired_o  (long_hold_fired_o),
    .toggle_request_o   (toggle_request_o),
    .stable_level_o     (stable_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("button_click_detector_core regression: fail");
      $finish;
    end
  end

  // register writes, returned items and accepted ticks, in that order per edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.note_cfg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (out_valid_o && out_ready_i) begin
        seen_result.event_code       = event_e'(event_code_o);
        seen_result.down_fired       = down_fired_o;
        seen_result.up_fired         = up_fired_o;
        seen_result.repeat_fired     = repeat_fired_o;
        seen_result.single_fired     = single_fired_o;
        seen_result.double_fired     = double_fired_o;
        seen_result.long_start_fired = long_start_fired_o;
        seen_result.long_hold_fired  = long_hold_fired_o;
        seen_result.toggle_request   = toggle_request_o;
        seen_result.stable_level     = stable_level_o;
        sb.check_result(seen_result);
      end
      if (in_valid_i && in_ready_o) sb.note_tick(pin_level_i);
    end
  end

  // receiver: windows of differing stall rates, plus the long hold-off on request
  initial begin
    int stall_left;
    int stall_pct;
    stall_left = 0;
    stall_pct  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(10, 120);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 50;
            default: stall_pct = 70;
          endcase
        end
        stall_left--;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_tick(input logic lvl);
    if (burst_left <= 0) begin
      burst_left = quiet ? 1000 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    pin_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic run_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_config(input logic [CfgDataW-1:0] deb, input logic [CfgDataW-1:0] short_v,
                              input logic [CfgDataW-1:0] long_v, input logic [CfgDataW-1:0] act);
    put_reg(REG_DEBOUNCE, deb);
    put_reg(REG_SHORT, short_v);
    put_reg(REG_LONG, long_v);
    put_reg(REG_ACTIVE, act);
    cfg_valid_i <= 1'b0;
    cur_deb   = int'(deb[DebW-1:0]);
    cur_short = int'(short_v);
    cur_long  = int'(long_v);
    cur_act   = act[0];
  endtask

  // stop offering, let every item come back, then let the block sit idle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int seg_len(input int near_a, input int near_b);
    int len;
    case ($urandom_range(0, 3))
      0: len = int'($urandom_range(1, cur_deb + 2));
      1: len = near_a + cur_deb + int'($urandom_range(0, 6)) - 3;
      2: len = near_b + cur_deb + int'($urandom_range(0, 6)) - 3;
      default: len = int'($urandom_range(1, 3 * near_a + 8));
    endcase
    if (len < 1) len = 1;
    if (len > MaxSeg) len = MaxSeg;
    return len;
  endfunction

  // mostly press / release runs shaped around the limits, some glitches and raw noise
  task automatic run_random(input int n);
    int   sent;
    int   len;
    int   glitch_at;
    logic lvl;
    sent = 0;
    lvl  = cur_act;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len && sent < n; i++) begin
          send_tick(1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        len = (lvl == cur_act) ? seg_len(cur_short, cur_long) : seg_len(cur_short, cur_short);
        glitch_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len - 1)) : -1;
        for (int i = 0; i < len && sent < n; i++) begin
          if (i == glitch_at) begin
            repeat ($urandom_range(1, (cur_deb > 1) ? cur_deb - 1 : 1)) begin
              send_tick(!lvl);
              sent++;
            end
          end
          send_tick(lvl);
          sent++;
        end
        lvl = !lvl;
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_DEBOUNCE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pin_level_i <= 1'b0;
    out_ready_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero debounce, tiny limits: every event and the click corner cases
    write_config(16'd0, 16'd2, 16'd3, 16'd0);
    run_level(1'b0, 1);
    run_level(1'b1, 1);
    run_level(1'b0, 1);
    run_level(1'b1, 5);
    run_level(1'b0, 6);
    run_level(1'b1, 1);
    run_level(1'b0, 1);
    run_level(1'b1, 5);
    // late release after the second press
    run_level(1'b0, 1);
    run_level(1'b1, 1);
    run_level(1'b0, 3);
    run_level(1'b1, 2);
    // fast burst that saturates the press count
    repeat (8) begin
      run_level(1'b0, 1);
      run_level(1'b1, 1);
    end
    run_level(1'b1, 4);
    drain();

    // top limits: a long press and a click timeout never come
    write_config(16'h0007, 16'hFFFF, 16'hFFFF, 16'h0000);
    quiet = 1'b1;
    run_level(1'b0, 200);
    run_level(1'b1, 20);
    quiet = 1'b0;
    run_random(230);
    drain();

    write_config(16'hFFF9, 16'd1, 16'd1, 16'hFFFF);
    run_random(230);
    drain();

    write_config(16'd3, 16'd60, 16'd200, 16'd0);
    run_random(230);
    drain();

    write_config(16'd2, 16'd5, 16'd12, 16'd1);
    hold_off_req = 1'b1;
    run_random(230);
    drain();

    write_config(16'd4, 16'd10, 16'd30, 16'd0);
    run_random(230);
    drain();

    write_config(16'd0, 16'd0, 16'd0, 16'd1);
    run_random(230);
    drain();

    write_config(16'd5, 16'd20, 16'd8, 16'd1);
    run_random(230);
    drain();

    write_config(16'h8006, 16'd7, 16'd40, 16'hFFFE);
    run_random(230);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("button_click_detector_core regression: pass");
    end else begin
      $display("button_click_detector_core regression: fail");
    end
    $finish;
  end

endmodule
